FILE: design/cfdsp_pkg.sv
// Shared types and constants for the command frame decoder and soft PWM.
`default_nettype none
package cfdsp_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 9;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned DirW     = 2;
  localparam int unsigned ServoW   = 13;
  localparam int unsigned PinsW    = 4;
  localparam int unsigned PwmPinsW = 3;
  localparam int unsigned DutyIdxW = 2;
  localparam int unsigned CntW     = 16;
  localparam int unsigned PeriodW  = 8;

  // Parameter defaults
  localparam int unsigned PWM_PERIOD_DEF   = 255;
  localparam int unsigned PWM_CHANNELS_DEF = 3;

  // Input word kinds
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Motor direction codes
  localparam logic [DirW-1:0] DIR_STOP = 2'd0;
  localparam logic [DirW-1:0] DIR_FWD  = 2'd1;
  localparam logic [DirW-1:0] DIR_REV  = 2'd2;

  // Frame channel numbers
  localparam logic [ChanW-1:0] CH_LEFT    = 4'd4;
  localparam logic [ChanW-1:0] CH_PWM0    = 4'd5;
  localparam logic [ChanW-1:0] CH_PWM1    = 4'd6;
  localparam logic [ChanW-1:0] CH_RIGHT   = 4'd7;
  localparam logic [ChanW-1:0] CH_SERVO_B = 4'd8;
  localparam logic [ChanW-1:0] CH_PWM2    = 4'd9;
  localparam logic [ChanW-1:0] CH_PIN0    = 4'd10;
  localparam logic [ChanW-1:0] CH_PIN3    = 4'd13;

  // Soft PWM slots addressed by the duty channels
  localparam logic [DutyIdxW-1:0] DUTY_IDX0 = 2'd0;
  localparam logic [DutyIdxW-1:0] DUTY_IDX1 = 2'd1;
  localparam logic [DutyIdxW-1:0] DUTY_IDX2 = 2'd2;

  // Command values
  localparam logic [ValueW-1:0] VAL_REV  = 9'h000;
  localparam logic [ValueW-1:0] VAL_FWD  = 9'h0B4;
  localparam logic [ValueW-1:0] VAL_STOP = 9'h0FF;
  localparam logic [ValueW-1:0] VAL_KEEP = 9'h0FF;

  localparam logic [ServoW-1:0] SERVO_MUL = 13'd11;
  localparam logic [ServoW-1:0] SERVO_OFS = 13'd500;

  // Duty write from the frame decoder to the soft PWM
  typedef struct packed {
    logic                en;
    logic [DutyIdxW-1:0] idx;
    logic [ValueW-1:0]   value;
  } duty_wr_t;

endpackage
`default_nettype wire

FILE: design/command_frame_decoder_soft_pwm_core.sv
// Command frame decoder with soft PWM: input register, state update, result handshake.
//
// Input channel: in_valid/in_stall carry one word, in_action selects a received
// command byte (in_rx_byte) or one soft PWM tick. Result channel: out_valid/
// out_stall carry one word per input word, showing frame completion and the
// motor, servo, digital pin and soft PWM levels after that word.
// An accepted word is held in the input register and is applied to the state
// once the result register is free; its result is presented from then on.
// Throughput: one word per cycle unless out_stall holds a result. The block state
// itself acts as the result register, so every decode and PWM update is one short
// path from the input register into that state.
// Stall: while out_stall holds a pending result, the state does not change; one
// more word is taken into the input register and then in_stall rises.
// Reset (rst_n low, synchronous): frame decoder waits for a header, motors
// stop, servo compares, pins, duties, counters and levels clear, both
// registers empty.
`default_nettype none
module command_frame_decoder_soft_pwm_core #(
  parameter int unsigned PWM_PERIOD   = cfdsp_pkg::PWM_PERIOD_DEF,
  parameter int unsigned PWM_CHANNELS = cfdsp_pkg::PWM_CHANNELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_action,
  input  wire logic [cfdsp_pkg::ByteW-1:0]     in_rx_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_frame_done,
  output logic [cfdsp_pkg::DirW-1:0]           out_left_motor,
  output logic [cfdsp_pkg::DirW-1:0]           out_right_motor,
  output logic [cfdsp_pkg::ServoW-1:0]         out_servo_a,
  output logic [cfdsp_pkg::ServoW-1:0]         out_servo_b,
  output logic [cfdsp_pkg::PinsW-1:0]          out_digital_pins,
  output logic [cfdsp_pkg::PwmPinsW-1:0]       out_pwm_pins
);
  import cfdsp_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_action_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             out_valid_r, out_valid_nxt;
  logic             in_acc;
  logic             adv;
  duty_wr_t         duty_wr;

  // advance the held word into the state when the result slot is free
  assign adv          = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && out_valid_r && out_stall;
  assign in_acc       = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_rx_byte;
    end
  end

  cfdsp_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (adv),
    .byte_en    (adv && (s1_action_r == ACT_BYTE)),
    .rx_byte    (s1_byte_r),
    .frame_done (out_frame_done),
    .left_dir   (out_left_motor),
    .right_dir  (out_right_motor),
    .servo_a    (out_servo_a),
    .servo_b    (out_servo_b),
    .pins       (out_digital_pins),
    .duty_wr    (duty_wr)
  );

  cfdsp_pwm #(
    .PWM_PERIOD   (PWM_PERIOD),
    .PWM_CHANNELS (PWM_CHANNELS)
  ) u_pwm (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_en  (adv && (s1_action_r == ACT_TICK)),
    .duty_wr  (duty_wr),
    .pwm_pins (out_pwm_pins)
  );

  assign out_valid = out_valid_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with a free input register");

  a_tick_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_action_r == ACT_TICK) |=> !out_frame_done)
    else $error("tick reported a completed frame");

  a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_pwm_pins) && $stable(out_digital_pins))
    else $error("state changed while the result was stalled");

endmodule
`default_nettype wire

FILE: design/cfdsp_frame.sv
// Two-byte command frame decoder holding motor, servo and pin state.
`default_nettype none
module cfdsp_frame (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step_en,
  input  wire logic                         byte_en,
  input  wire logic [cfdsp_pkg::ByteW-1:0]  rx_byte,
  output logic                              frame_done,
  output logic [cfdsp_pkg::DirW-1:0]        left_dir,
  output logic [cfdsp_pkg::DirW-1:0]        right_dir,
  output logic [cfdsp_pkg::ServoW-1:0]      servo_a,
  output logic [cfdsp_pkg::ServoW-1:0]      servo_b,
  output logic [cfdsp_pkg::PinsW-1:0]       pins,
  output cfdsp_pkg::duty_wr_t               duty_wr
);
  import cfdsp_pkg::*;

  typedef enum logic [1:0] {
    ST_HDR  = 2'b01,
    ST_DATA = 2'b10
  } stage_t;

  stage_t              stage_r, stage_nxt;
  logic [ByteW-1:0]    hdr_r, hdr_nxt;
  logic                done_r, done_nxt;
  logic [DirW-1:0]     left_r, left_nxt;
  logic [DirW-1:0]     right_r, right_nxt;
  logic [ServoW-1:0]   servo_a_r, servo_a_nxt;
  logic [ServoW-1:0]   servo_b_r, servo_b_nxt;
  logic [PinsW-1:0]    pins_r, pins_nxt;

  logic [ChanW-1:0]    chan;
  logic [ValueW-1:0]   value;
  logic [ServoW-1:0]   servo_cmp;
  logic [1:0]          pin_idx;
  logic                apply;

  assign chan      = hdr_r[6:3];
  assign value     = {hdr_r[1:0], rx_byte[6:0]};
  assign servo_cmp = ServoW'(value) * SERVO_MUL + SERVO_OFS;
  assign pin_idx   = 2'(chan - CH_PIN0);
  assign apply     = byte_en && (stage_r == ST_DATA) && !rx_byte[7];

  function automatic logic [DirW-1:0] motor_next(logic [DirW-1:0] cur,
                                                 logic [ValueW-1:0] v);
    logic [DirW-1:0] res;
    res = cur;
    if (v == VAL_REV) res = DIR_REV;
    else if (v == VAL_FWD) res = DIR_FWD;
    else if (v == VAL_STOP) res = DIR_STOP;
    return res;
  endfunction

  always_comb begin
    stage_nxt     = stage_r;
    hdr_nxt       = hdr_r;
    done_nxt      = done_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    servo_a_nxt   = servo_a_r;
    servo_b_nxt   = servo_b_r;
    pins_nxt      = pins_r;
    duty_wr.en    = 1'b0;
    duty_wr.idx   = DUTY_IDX0;
    duty_wr.value = value;

    // every word, byte or tick, refreshes the completion flag
    if (step_en) done_nxt = apply;

    if (byte_en) begin
      case (stage_r)
        ST_HDR: begin
          if (rx_byte[7]) begin
            hdr_nxt   = rx_byte;
            stage_nxt = ST_DATA;
          end
        end
        ST_DATA: begin
          // any byte returns to header wait; a second header drops the frame
          stage_nxt = ST_HDR;
        end
        default: stage_nxt = ST_HDR;
      endcase
    end

    if (apply) begin
      case (chan) inside
        CH_LEFT: begin
          left_nxt = motor_next(left_r, value);
          if (value != VAL_KEEP) servo_a_nxt = servo_cmp;
        end
        CH_PWM0: begin
          duty_wr.en  = 1'b1;
          duty_wr.idx = DUTY_IDX0;
        end
        CH_PWM1: begin
          duty_wr.en  = 1'b1;
          duty_wr.idx = DUTY_IDX1;
        end
        CH_RIGHT: right_nxt = motor_next(right_r, value);
        CH_SERVO_B: begin
          if (value != VAL_KEEP) servo_b_nxt = servo_cmp;
        end
        CH_PWM2: begin
          duty_wr.en  = 1'b1;
          duty_wr.idx = DUTY_IDX2;
        end
        [CH_PIN0:CH_PIN3]: pins_nxt[pin_idx] = (value != '0);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_HDR;
      hdr_r     <= '0;
      done_r    <= 1'b0;
      left_r    <= DIR_STOP;
      right_r   <= DIR_STOP;
      servo_a_r <= '0;
      servo_b_r <= '0;
      pins_r    <= '0;
    end else begin
      stage_r   <= stage_nxt;
      hdr_r     <= hdr_nxt;
      done_r    <= done_nxt;
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      servo_a_r <= servo_a_nxt;
      servo_b_r <= servo_b_nxt;
      pins_r    <= pins_nxt;
    end
  end

  assign frame_done = done_r;
  assign left_dir   = left_r;
  assign right_dir  = right_r;
  assign servo_a    = servo_a_r;
  assign servo_b    = servo_b_r;
  assign pins       = pins_r;

  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    left_r != 2'd3 && right_r != 2'd3)
    else $error("motor direction holds an unused code");

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    servo_a_r <= 13'd6121 && servo_b_r <= 13'd6121)
    else $error("servo compare out of range");

  a_done_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $past(stage_r) == ST_DATA)
    else $error("frame completed without a pending header");

endmodule
`default_nettype wire

FILE: design/cfdsp_pwm.sv
// Soft PWM: period counter, per-channel counters, duties and pin levels.
`default_nettype none
module cfdsp_pwm #(
  parameter int unsigned PWM_PERIOD   = cfdsp_pkg::PWM_PERIOD_DEF,
  parameter int unsigned PWM_CHANNELS = cfdsp_pkg::PWM_CHANNELS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           tick_en,
  input  wire cfdsp_pkg::duty_wr_t            duty_wr,
  output logic [cfdsp_pkg::PwmPinsW-1:0]      pwm_pins
);
  import cfdsp_pkg::*;

  localparam logic [PeriodW-1:0] PeriodCode = PeriodW'(PWM_PERIOD);

  logic [PeriodW-1:0]      period_r, period_nxt;
  logic [CntW-1:0]         cnt_r [PWM_CHANNELS];
  logic [CntW-1:0]         cnt_nxt [PWM_CHANNELS];
  logic [ValueW-1:0]       duty_r [PWM_CHANNELS];
  logic [ValueW-1:0]       duty_nxt [PWM_CHANNELS];
  logic [PWM_CHANNELS-1:0] lvl_r, lvl_nxt;
  logic [PeriodW-1:0]      period_inc;
  logic                    period_hit;

  assign period_inc = period_r + 8'd1;
  assign period_hit = (period_inc == PeriodCode);

  always_comb begin
    period_nxt = period_r;
    cnt_nxt    = cnt_r;
    duty_nxt   = duty_r;
    lvl_nxt    = lvl_r;
    if (tick_en) begin
      period_nxt = period_hit ? '0 : period_inc;
      for (int i = 0; i < PWM_CHANNELS; i++) begin
        if (period_hit) begin
          if (cnt_nxt[i] == CntW'(duty_r[i]) && duty_r[i] != '0) begin
            lvl_nxt[i] = 1'b1;
            cnt_nxt[i] = '0;
          end else begin
            lvl_nxt[i] = 1'b0;
          end
        end
        // drop the level on a duty match, else advance the counter
        if (cnt_nxt[i] == CntW'(duty_r[i])) begin
          lvl_nxt[i] = 1'b0;
        end else begin
          cnt_nxt[i] = cnt_nxt[i] + 16'd1;
        end
      end
    end
    if (duty_wr.en) begin
      for (int i = 0; i < PWM_CHANNELS; i++) begin
        if (int'(duty_wr.idx) == i) duty_nxt[i] = duty_wr.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      lvl_r    <= '0;
      for (int i = 0; i < PWM_CHANNELS; i++) begin
        cnt_r[i]  <= '0;
        duty_r[i] <= '0;
      end
    end else begin
      period_r <= period_nxt;
      lvl_r    <= lvl_nxt;
      cnt_r    <= cnt_nxt;
      duty_r   <= duty_nxt;
    end
  end

  for (genvar j = 0; j < PwmPinsW; j++) begin : g_pin
    if (j < PWM_CHANNELS) begin : g_on
      assign pwm_pins[j] = lvl_r[j];
    end else begin : g_off
      assign pwm_pins[j] = 1'b0;
    end
  end

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    period_r < PeriodCode)
    else $error("period counter passed the period end");

  a_period_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_en |=> $stable(period_r))
    else $error("period counter moved without a tick");

  a_level_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !tick_en |=> $stable(lvl_r))
    else $error("pin levels changed without a tick");

endmodule
`default_nettype wire
